[hw/rtl/hru_pkg.sv]
// shared types, constants and functions of the half rgba unpremultiplier
package hru_pkg;

  localparam int HALF_W = 16;
  localparam int FLT_W  = 32;
  localparam int UN_W   = 8;

  localparam logic [FLT_W-1:0] ALPHA_EPS_BITS = 32'h358637BD;  // 1e-6 in binary32
  localparam logic [FLT_W-1:0] QNAN_CANON     = 32'h7FC00000;
  localparam logic [FLT_W-1:0] QUIET_BIT      = 32'h00400000;
  localparam logic [FLT_W-1:0] ONE_BITS       = 32'h3F800000;
  localparam logic [UN_W-1:0]  UNORM_MAX      = 8'hFF;

  // divider: 26 quotient bits spread over four stages, then a rounding stage
  localparam int DIV_STAGES    = 4;
  localparam int DIV_MAX_STEPS = 7;
  localparam int DIV_LAT       = DIV_STAGES + 1;
  localparam int UNORM_LAT     = 2;
  localparam int PIPE_DEPTH    = 1 + DIV_LAT + UNORM_LAT;

  typedef struct packed {
    logic [FLT_W-1:0] red;
    logic [FLT_W-1:0] green;
    logic [FLT_W-1:0] blue;
    logic [FLT_W-1:0] alpha;
  } flt_px_t;

  typedef struct packed {
    flt_px_t         flt;
    logic [UN_W-1:0] un_red;
    logic [UN_W-1:0] un_green;
    logic [UN_W-1:0] un_blue;
    logic [UN_W-1:0] un_alpha;
    logic            last;
  } out_word_t;

  typedef struct packed {
    logic             sign;
    logic [8:0]       exp;
    logic             special;
    logic [FLT_W-1:0] spec_val;
    logic [10:0]      mb;
    logic [11:0]      rem;
    logic [25:0]      quo;
  } div_st_t;

  function automatic int div_stage_steps(input int s);
    return (s < 2) ? 7 : 6;
  endfunction

  function automatic logic is_nan(input logic [FLT_W-1:0] b);
    return (&b[30:23]) && (|b[22:0]);
  endfunction

  function automatic logic [FLT_W-1:0] half_to_single(input logic [HALF_W-1:0] h);
    logic [FLT_W-1:0] res;
    logic [3:0]       p;
    logic [9:0]       m;
    logic [7:0]       e;
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h[i]) p = 4'(i);
    end
    // leading one moves to bit 10 and falls off the 10-bit field
    m = 10'(h[9:0] << (4'd10 - p));
    e = 8'd103 + {4'd0, p};
    if (h[14:10] == 5'd0) begin
      res = (h[9:0] == 10'd0) ? {h[15], 31'd0} : {h[15], e, m, 13'd0};
    end else if (h[14:10] == 5'h1F) begin
      res = {h[15], 8'hFF, h[9:0], 13'd0};
    end else begin
      res = {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
    end
    return res;
  endfunction

  function automatic div_st_t div_step(input div_st_t st);
    div_st_t    o;
    logic       qb;
    logic [11:0] sub;
    o   = st;
    qb  = st.rem >= {1'b0, st.mb};
    sub = qb ? (st.rem - {1'b0, st.mb}) : st.rem;
    o.rem = {sub[10:0], 1'b0};
    o.quo = {st.quo[24:0], qb};
    return o;
  endfunction

  function automatic div_st_t div_run(input div_st_t st, input int n);
    div_st_t o;
    o = st;
    for (int i = 0; i < DIV_MAX_STEPS; i++) begin
      if (i < n) o = div_step(o);
    end
    return o;
  endfunction

endpackage

[hw/rtl/hru_if.sv]
// pixel channel interfaces: half input words and float/unorm result words
interface hru_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic [hru_pkg::HALF_W-1:0]  half_red;
  logic [hru_pkg::HALF_W-1:0]  half_green;
  logic [hru_pkg::HALF_W-1:0]  half_blue;
  logic [hru_pkg::HALF_W-1:0]  half_alpha;
  logic                        last_pixel;

  modport source (output valid, half_red, half_green, half_blue, half_alpha, last_pixel,
                  input ready);
  modport sink (input valid, half_red, half_green, half_blue, half_alpha, last_pixel,
                output ready);
endinterface

interface hru_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [hru_pkg::FLT_W-1:0]  float_red;
  logic [hru_pkg::FLT_W-1:0]  float_green;
  logic [hru_pkg::FLT_W-1:0]  float_blue;
  logic [hru_pkg::FLT_W-1:0]  float_alpha;
  logic [hru_pkg::UN_W-1:0]   unorm_red;
  logic [hru_pkg::UN_W-1:0]   unorm_green;
  logic [hru_pkg::UN_W-1:0]   unorm_blue;
  logic [hru_pkg::UN_W-1:0]   unorm_alpha;
  logic                       last_out;

  modport source (output valid, float_red, float_green, float_blue, float_alpha,
                  unorm_red, unorm_green, unorm_blue, unorm_alpha, last_out,
                  input ready);
  modport sink (input valid, float_red, float_green, float_blue, float_alpha,
                unorm_red, unorm_green, unorm_blue, unorm_alpha, last_out,
                output ready);
endinterface

[hw/rtl/hru_expand.sv]
// binary16 to binary32 expansion of one pixel and the alpha threshold test
module hru_expand (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hru_pkg::HALF_W-1:0] half_red,
  input  logic [hru_pkg::HALF_W-1:0] half_green,
  input  logic [hru_pkg::HALF_W-1:0] half_blue,
  input  logic [hru_pkg::HALF_W-1:0] half_alpha,
  output hru_pkg::flt_px_t           px_q,
  output logic                       alpha_ok_q
);
  import hru_pkg::*;

  flt_px_t px_nxt;
  logic    alpha_ok_nxt;
  flt_px_t px_r;
  logic    alpha_ok_r;

  always_comb begin
    px_nxt.red   = half_to_single(half_red);
    px_nxt.green = half_to_single(half_green);
    px_nxt.blue  = half_to_single(half_blue);
    px_nxt.alpha = half_to_single(half_alpha);
    // positive, not nan and above the epsilon: plain unsigned compare of the bits
    alpha_ok_nxt = !is_nan(px_nxt.alpha) && !px_nxt.alpha[31] &&
                   (px_nxt.alpha[30:0] > ALPHA_EPS_BITS[30:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r       <= px_nxt;
      alpha_ok_r <= alpha_ok_nxt;
    end
  end

  assign px_q       = px_r;
  assign alpha_ok_q = alpha_ok_r;
endmodule

[hw/rtl/hru_div.sv]
// pipelined binary32 divide of an expanded half by a positive expanded half
module hru_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hru_pkg::FLT_W-1:0] num,
  input  logic [hru_pkg::FLT_W-1:0] den,
  input  logic                      den_ok,
  output logic [hru_pkg::FLT_W-1:0] quo_bits
);
  import hru_pkg::*;

  div_st_t           init;
  div_st_t           st_r [DIV_STAGES];
  logic [FLT_W-1:0]  res_nxt;
  logic [FLT_W-1:0]  res_r;
  logic              num_inf;
  logic              den_inf;
  logic [23:0]       mant;
  logic              g;
  logic              s;
  logic [7:0]        e;
  logic [30:0]       word;

  always_comb begin
    num_inf = (num[30:23] == 8'hFF) && (num[22:0] == 23'd0);
    den_inf = (den[30:23] == 8'hFF);
    init.sign     = num[31];
    init.exp      = {1'b0, num[30:23]} - {1'b0, den[30:23]} + 9'd127;
    init.mb       = {1'b1, den[22:13]};
    init.rem      = {2'b01, num[22:13]};
    init.quo      = '0;
    init.special  = 1'b1;
    init.spec_val = '0;
    if (!den_ok) begin
      init.spec_val = '0;
    end else if (is_nan(num)) begin
      init.spec_val = num | QUIET_BIT;
    end else if (num_inf) begin
      init.spec_val = den_inf ? QNAN_CANON : {num[31], 8'hFF, 23'd0};
    end else if ((num[30:23] == 8'd0) || den_inf) begin
      init.spec_val = {num[31], 31'd0};
    end else begin
      init.special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_run(init, div_stage_steps(0));
      for (int i = 1; i < DIV_STAGES; i++) begin
        st_r[i] <= div_run(st_r[i-1], div_stage_steps(i));
      end
      res_r <= res_nxt;
    end
  end

  // quotient is never subnormal or overflowing for half operands above the epsilon
  always_comb begin
    if (st_r[DIV_STAGES-1].quo[25]) begin
      mant = st_r[DIV_STAGES-1].quo[25:2];
      g    = st_r[DIV_STAGES-1].quo[1];
      s    = st_r[DIV_STAGES-1].quo[0] | (|st_r[DIV_STAGES-1].rem);
      e    = st_r[DIV_STAGES-1].exp[7:0];
    end else begin
      mant = st_r[DIV_STAGES-1].quo[24:1];
      g    = st_r[DIV_STAGES-1].quo[0];
      s    = |st_r[DIV_STAGES-1].rem;
      e    = 8'(st_r[DIV_STAGES-1].exp - 9'd1);
    end
    // round to nearest even, carry runs into the exponent
    word    = {e, mant[22:0]} + {30'd0, g & (s | mant[0])};
    res_nxt = st_r[DIV_STAGES-1].special ? st_r[DIV_STAGES-1].spec_val
                                         : {st_r[DIV_STAGES-1].sign, word};
  end

  assign quo_bits = res_r;
endmodule

[hw/rtl/hru_unorm.sv]
// binary32 to 8-bit unorm: clamp, scale by 255 in binary32, round half up
module hru_unorm (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hru_pkg::FLT_W-1:0] flt,
  output logic [hru_pkg::FLT_W-1:0] flt_q,
  output logic [hru_pkg::UN_W-1:0]  unorm
);
  import hru_pkg::*;

  logic              sat;
  logic              zero;
  logic [23:0]       m;
  logic [31:0]       p;
  logic [24:0]       rnd;
  logic [32:0]       pr;
  logic [8:0]        sh;

  logic [FLT_W-1:0]  flt1_r;
  logic              sat1_r;
  logic              zero1_r;
  logic [32:0]       pr1_r;
  logic [5:0]        sh1_r;

  logic [32:0]       t;
  logic [10:0]       v;
  logic [UN_W-1:0]   unorm_nxt;
  logic [FLT_W-1:0]  flt2_r;
  logic [UN_W-1:0]   unorm2_r;

  always_comb begin
    sat  = !is_nan(flt) && !flt[31] && (flt[30:0] >= ONE_BITS[30:0]);
    sh   = 9'd150 - {1'b0, flt[30:23]};
    zero = is_nan(flt) || flt[31] || (flt[30:23] == 8'd0) || (sh > 9'd40);
    m    = {1'b1, flt[22:0]};
    p    = {m, 8'd0} - {8'd0, m};
    // product rounded back to 24 significant bits
    if (p[31]) begin
      rnd = {1'b0, p[31:8]} + {24'd0, p[7] & ((|p[6:0]) | p[8])};
      pr  = {rnd, 8'd0};
    end else begin
      rnd = {1'b0, p[30:7]} + {24'd0, p[6] & ((|p[5:0]) | p[7])};
      pr  = {1'b0, rnd, 7'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flt1_r   <= flt;
      sat1_r   <= sat;
      zero1_r  <= zero;
      pr1_r    <= pr;
      sh1_r    <= sh[5:0];
      flt2_r   <= flt1_r;
      unorm2_r <= unorm_nxt;
    end
  end

  always_comb begin
    t = pr1_r >> (sh1_r - 6'd1);
    v = {1'b0, t[9:0]} + 11'd1;
    if (sat1_r) begin
      unorm_nxt = UNORM_MAX;
    end else if (zero1_r) begin
      unorm_nxt = '0;
    end else if (v[10:1] > 10'd255) begin
      unorm_nxt = UNORM_MAX;
    end else begin
      unorm_nxt = v[8:1];
    end
  end

  assign flt_q = flt2_r;
  assign unorm = unorm2_r;
endmodule

[hw/rtl/half_rgba_unpremultiply_unorm8.sv]
// Half RGBA unpremultiplier with binary32 and 8-bit unorm results.
// in_pix carries one premultiplied pixel per word as four binary16 channels
// and a last flag; out_pix returns one word per pixel: four binary32 values
// (red, green, blue divided by alpha, alpha itself) and four unorm8 values.
// Both channels use valid/ready; a word moves when both are high.
// Throughput is one pixel per clock while out_pix is ready. A pixel passes
// one expansion stage, four divide stages of 6 or 7 quotient bits each, a
// rounding stage, two unorm stages and the output register to out_pix.valid.
// When out_pix stalls, one word is parked in a skid register and the whole
// pipeline freezes; in_pix.ready comes straight from that register, so
// nothing is lost or repeated. Alpha at or below 1e-6 or NaN gives zero
// colour; NaN gives unorm 0.
// Reset (rst_n low, synchronous) empties the pipeline and the output side.
module half_rgba_unpremultiply_unorm8 (
  input logic           clk,
  input logic           rst_n,
  hru_pix_in_if.sink    in_pix,
  hru_pix_out_if.source out_pix
);
  import hru_pkg::*;

  logic             en;
  logic             vld_r  [PIPE_DEPTH];
  logic             last_r [PIPE_DEPTH];
  flt_px_t          px;
  logic             alpha_ok;
  logic [FLT_W-1:0] alpha_r [DIV_LAT];
  logic [FLT_W-1:0] quo_red;
  logic [FLT_W-1:0] quo_green;
  logic [FLT_W-1:0] quo_blue;
  out_word_t        last_word;
  out_word_t        out_word_r;
  out_word_t        skid_word_r;
  logic             out_valid_r;
  logic             skid_full_r;
  logic             accept_last;

  assign en           = !skid_full_r;
  assign in_pix.ready = en;
  assign accept_last  = en && vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_pix.valid;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r[0]  <= in_pix.last_pixel;
      for (int i = 1; i < PIPE_DEPTH; i++) last_r[i] <= last_r[i-1];
      alpha_r[0] <= px.alpha;
      for (int i = 1; i < DIV_LAT; i++) alpha_r[i] <= alpha_r[i-1];
    end
  end

  hru_expand u_expand (
    .clk        (clk),
    .en         (en),
    .half_red   (in_pix.half_red),
    .half_green (in_pix.half_green),
    .half_blue  (in_pix.half_blue),
    .half_alpha (in_pix.half_alpha),
    .px_q       (px),
    .alpha_ok_q (alpha_ok)
  );

  hru_div u_div_red (
    .clk (clk), .en (en), .num (px.red), .den (px.alpha), .den_ok (alpha_ok),
    .quo_bits (quo_red)
  );
  hru_div u_div_green (
    .clk (clk), .en (en), .num (px.green), .den (px.alpha), .den_ok (alpha_ok),
    .quo_bits (quo_green)
  );
  hru_div u_div_blue (
    .clk (clk), .en (en), .num (px.blue), .den (px.alpha), .den_ok (alpha_ok),
    .quo_bits (quo_blue)
  );

  hru_unorm u_unorm_red (
    .clk (clk), .en (en), .flt (quo_red),
    .flt_q (last_word.flt.red), .unorm (last_word.un_red)
  );
  hru_unorm u_unorm_green (
    .clk (clk), .en (en), .flt (quo_green),
    .flt_q (last_word.flt.green), .unorm (last_word.un_green)
  );
  hru_unorm u_unorm_blue (
    .clk (clk), .en (en), .flt (quo_blue),
    .flt_q (last_word.flt.blue), .unorm (last_word.un_blue)
  );
  hru_unorm u_unorm_alpha (
    .clk (clk), .en (en), .flt (alpha_r[DIV_LAT-1]),
    .flt_q (last_word.flt.alpha), .unorm (last_word.un_alpha)
  );

  assign last_word.last = last_r[PIPE_DEPTH-1];

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_pix.ready) begin
      out_valid_r <= skid_full_r || accept_last;
      skid_full_r <= 1'b0;
    end else if (accept_last) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_pix.ready) begin
      out_word_r <= skid_full_r ? skid_word_r : last_word;
    end else if (accept_last) begin
      skid_word_r <= last_word;
    end
  end

  assign out_pix.valid       = out_valid_r;
  assign out_pix.float_red   = out_word_r.flt.red;
  assign out_pix.float_green = out_word_r.flt.green;
  assign out_pix.float_blue  = out_word_r.flt.blue;
  assign out_pix.float_alpha = out_word_r.flt.alpha;
  assign out_pix.unorm_red   = out_word_r.un_red;
  assign out_pix.unorm_green = out_word_r.un_green;
  assign out_pix.unorm_blue  = out_word_r.un_blue;
  assign out_pix.unorm_alpha = out_word_r.un_alpha;
  assign out_pix.last_out    = out_word_r.last;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept_last |=> out_valid_r)
    else $error("word leaving the pipeline was dropped");

  a_alpha_one_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.flt.alpha == ONE_BITS) |-> out_word_r.un_alpha == UNORM_MAX)
    else $error("alpha of one did not give full unorm");
`endif
endmodule

[tb/sv/hru_pixel_checker.sv]
// pixel checker: predicts unpremultiplied float and unorm words and compares them
`timescale 1ns / 1ps

module hru_pixel_checker (
  input  logic   clk,
  input  logic   rst_n,
  hru_pix_in_if  in_mon,
  hru_pix_out_if out_mon,
  output int     fail_count,
  output int     pending_count
);
  import hru_pkg::*;

  out_word_t expected_pixels[$];

  function automatic logic nan_bits(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    int          e32;
    logic [10:0] m;
    sgn = {h[15], 31'd0};
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) return sgn;
      e32 = 113;
      m   = {1'b0, h[9:0]};
      while (!m[10]) begin
        m   = m << 1;
        e32 = e32 - 1;
      end
      return sgn | {1'b0, 8'(e32), m[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return sgn | {1'b0, 8'hFF, h[9:0], 13'd0};
    return sgn | {1'b0, 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
  endfunction

  // binary32 divide by a positive alpha, round to nearest even
  function automatic logic [31:0] divide_by_alpha(input logic [31:0] n, input logic [31:0] a);
    logic        sgn;
    logic [49:0] dividend;
    logic [49:0] q;
    logic [49:0] r;
    logic [24:0] mant;
    logic        guard;
    logic        sticky;
    int          e;
    if (nan_bits(n)) return n | QUIET_BIT;
    sgn = n[31];
    if (n[30:23] == 8'hFF) begin
      if (a[30:23] == 8'hFF) return QNAN_CANON;
      return {sgn, 8'hFF, 23'd0};
    end
    if (a[30:23] == 8'hFF || n[30:0] == 31'd0) return {sgn, 31'd0};
    dividend = 50'({1'b1, n[22:0]}) << 26;
    q = dividend / 50'({1'b1, a[22:0]});
    r = dividend % 50'({1'b1, a[22:0]});
    e = int'(n[30:23]) - int'(a[30:23]) + 127;
    if (q[26]) begin
      mant   = {1'b0, q[26:3]};
      guard  = q[2];
      sticky = (q[1:0] != 2'd0) || (r != 50'd0);
    end else begin
      e      = e - 1;
      mant   = {1'b0, q[25:2]};
      guard  = q[1];
      sticky = q[0] || (r != 50'd0);
    end
    if (guard && (sticky || mant[0])) mant = mant + 25'd1;
    if (mant[24]) begin
      mant = mant >> 1;
      e    = e + 1;
    end
    return {sgn, 8'(e), mant[22:0]};
  endfunction

  // clamp, scale by 255 with binary32 rounding, then round half away from zero
  function automatic logic [7:0] to_unorm(input logic [31:0] b);
    logic [31:0] prod;
    logic [31:0] kept;
    logic [63:0] val;
    int          s;
    int          k;
    if (nan_bits(b) || b[31] || b[30:0] == 31'd0) return 8'd0;
    if (b[30:0] >= ONE_BITS[30:0]) return UNORM_MAX;
    if (b[30:23] == 8'd0) return 8'd0;
    prod = {8'd0, 1'b1, b[22:0]} * 32'd255;
    s    = prod[31] ? 8 : 7;
    kept = prod >> s;
    if (prod[s-1] && (((prod & ((32'd1 << (s-1)) - 1)) != 32'd0) || kept[0]))
      kept = kept + 32'd1;
    k = 23 - (int'(b[30:23]) - 127) - s;
    if (k >= 60) return 8'd0;
    val = {32'd0, kept};
    if (k <= 0) val = val << (-k);
    else val = (val + (64'd1 << (k-1))) >> k;
    return (val >= 64'd255) ? UNORM_MAX : 8'(val);
  endfunction

  function automatic out_word_t unpremultiply(input logic [15:0] hr, input logic [15:0] hg,
                                              input logic [15:0] hb, input logic [15:0] ha,
                                              input logic lst);
    out_word_t w;
    logic [31:0] ab;
    ab = widen_half(ha);
    w  = '0;
    w.flt.alpha = ab;
    if (!nan_bits(ab) && !ab[31] && ab[30:0] > ALPHA_EPS_BITS[30:0]) begin
      w.flt.red   = divide_by_alpha(widen_half(hr), ab);
      w.flt.green = divide_by_alpha(widen_half(hg), ab);
      w.flt.blue  = divide_by_alpha(widen_half(hb), ab);
    end
    w.un_red   = to_unorm(w.flt.red);
    w.un_green = to_unorm(w.flt.green);
    w.un_blue  = to_unorm(w.flt.blue);
    w.un_alpha = to_unorm(ab);
    w.last     = lst;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = expected_pixels.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && in_mon.valid && in_mon.ready)
      expected_pixels.insert(expected_pixels.size(),
                             unpremultiply(in_mon.half_red, in_mon.half_green,
                                           in_mon.half_blue, in_mon.half_alpha,
                                           in_mon.last_pixel));
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result word with no pixel outstanding");
        fail_count++;
      end else begin
        w = expected_pixels.pop_front();
        check_field("float_red", w.flt.red, out_mon.float_red);
        check_field("float_green", w.flt.green, out_mon.float_green);
        check_field("float_blue", w.flt.blue, out_mon.float_blue);
        check_field("float_alpha", w.flt.alpha, out_mon.float_alpha);
        check_field("unorm_red", 32'(w.un_red), 32'(out_mon.unorm_red));
        check_field("unorm_green", 32'(w.un_green), 32'(out_mon.unorm_green));
        check_field("unorm_blue", 32'(w.un_blue), 32'(out_mon.unorm_blue));
        check_field("unorm_alpha", 32'(w.un_alpha), 32'(out_mon.unorm_alpha));
        check_field("last_out", 32'(w.last), 32'(out_mon.last_out));
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// testbench top: pixel stimulus, idling on both channels and the verdict
`timescale 1ns / 1ps

module tb;
  import hru_pkg::*;

  localparam int RANDOM_PIXELS = 1630;
  localparam int QUIET_TAIL    = 200;

  logic clk;
  logic rst_n;
  logic quiet;
  int   fail_count;
  int   pending_count;

  hru_pix_in_if  in_pix();
  hru_pix_out_if out_pix();

  half_rgba_unpremultiply_unorm8 DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  hru_pixel_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_pix),
    .out_mon       (out_pix),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[half_rgba_unpremultiply_unorm8] ERROR");
    $finish;
  end

  task automatic send_pixel(input logic [15:0] hr, input logic [15:0] hg,
                            input logic [15:0] hb, input logic [15:0] ha);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_pix.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.half_red   <= hr;
    in_pix.half_green <= hg;
    in_pix.half_blue  <= hb;
    in_pix.half_alpha <= ha;
    in_pix.last_pixel <= ($urandom_range(0, 7) == 0);
    do @(posedge clk); while (!in_pix.ready);
  endtask

  function automatic logic [15:0] odd_alpha();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 16'h0012));
      3: return 16'h7C00;
      4: return 16'h7C00 | 16'($urandom_range(1, 16'h03FF));
      5: return 16'h8000 | 16'($urandom);
      6: return 16'h7BFF;
      default: return 16'h3C00;
    endcase
  endfunction

  // directed words: {red, green, blue, alpha}
  logic [63:0] directed_pixels[] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3C00_3800_0000_3C00,
    64'h1C00_2000_3400_3C00, 64'h0001_03FF_0400_0011, 64'h0001_0001_0001_0010,
    64'h0001_0001_0001_0001, 64'h3C00_3C00_3C00_8000, 64'h3C00_3C00_3C00_BC00,
    64'h3C00_3C00_3C00_7E01, 64'h7C00_FC00_3C00_7C00, 64'h7C00_FC00_3C00_3C00,
    64'h7E55_FD01_7C01_3C00, 64'h8000_8001_BC00_3C00, 64'h7BFF_7BFF_0001_0001,
    64'h7BFF_0400_03FF_7BFF, 64'h3C00_3C01_3BFF_3C00, 64'h2E66_2E00_3555_3800,
    64'h1E00_1E01_1DFF_2A00, 64'h3800_3400_3000_7C00, 64'h5555_AAAA_3333_4000
  };

  initial begin
    logic [15:0] ha;
    quiet             = 1'b0;
    rst_n             = 1'b0;
    in_pix.valid      = 1'b0;
    in_pix.half_red   = '0;
    in_pix.half_green = '0;
    in_pix.half_blue  = '0;
    in_pix.half_alpha = '0;
    in_pix.last_pixel = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_pixels[i])
      send_pixel(directed_pixels[i][63:48], directed_pixels[i][47:32],
                 directed_pixels[i][31:16], directed_pixels[i][15:0]);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS - QUIET_TAIL) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // well-formed premultiplied pixel: colour no greater than alpha
          ha = 16'($urandom_range(16'h0011, 16'h3C00));
          send_pixel(16'($urandom_range(0, ha)), 16'($urandom_range(0, ha)),
                     16'($urandom_range(0, ha)), ha);
        end
        6:
          send_pixel(16'($urandom), 16'($urandom), 16'($urandom), odd_alpha());
        default:
          send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end
    in_pix.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[half_rgba_unpremultiply_unorm8] OK");
    end else begin
      $display("[half_rgba_unpremultiply_unorm8] ERROR");
    end
    $finish;
  end

  // result side stalls in bursts until the quiet tail
  initial begin
    out_pix.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      out_pix.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_pix.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

endmodule
